// ===== rtl/pit_pkg.sv =====
package pit_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [2:0] reg_index_t;

    localparam opcode_t OP_TICK  = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_WRITE = 2'd2;

    localparam reg_index_t REG_CR   = 3'd0;
    localparam reg_index_t REG_SR   = 3'd1;
    localparam reg_index_t REG_LR   = 3'd2;
    localparam reg_index_t REG_CMPR = 3'd3;
    localparam reg_index_t REG_CNR  = 3'd4;

    // Control register bit positions.
    localparam int CR_EN         = 0;
    localparam int CR_ENMOD      = 1;
    localparam int CR_OCIEN      = 2;
    localparam int CR_RLD        = 3;
    localparam int CR_PRESC_LSB  = 4;
    localparam int CR_PRESC_MSB  = 15;
    localparam int CR_SWR        = 16;
    localparam int CR_IOVW       = 17;
    localparam int CR_CLKSRC_LSB = 24;
    localparam int CR_CLKSRC_MSB = 25;

    // Bits of the control register that are stored; the rest read as zero.
    localparam logic [31:0] CR_KEEP = 32'h03EE_FFFF;

    localparam int SR_FLAG = 0;

    typedef struct packed {
        logic [31:0] read_data;
        logic        interrupt_line;
        logic        compare_flag;
    } pit_result_t;

endpackage

// ===== rtl/pit_core.sv =====
module pit_core
    import pit_pkg::*;
#(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  opcode_t     opcode,
    input  reg_index_t  reg_index,
    input  logic [31:0] write_data,
    output pit_result_t result
);

    logic [31:0]               ctrl_reg,  ctrl_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [COUNT_WIDTH-1:0]    load_reg,  load_next;
    logic [COUNT_WIDTH-1:0]    cmp_reg,   cmp_next;
    logic                      flag_reg,  flag_next;
    logic [PRESCALE_WIDTH-1:0] pre_reg,   pre_next;

    logic [PRESCALE_WIDTH-1:0] divider;
    logic [COUNT_WIDTH-1:0]    reload;
    logic [COUNT_WIDTH-1:0]    stepped;
    logic [31:0]               rd;

    assign divider = PRESCALE_WIDTH'(ctrl_reg[CR_PRESC_MSB:CR_PRESC_LSB]);
    assign reload  = ctrl_reg[CR_RLD] ? load_reg : '1;
    assign stepped = (count_reg == '0) ? reload : count_reg - COUNT_WIDTH'(1);

    always_comb
    begin
        ctrl_next  = ctrl_reg;
        count_next = count_reg;
        load_next  = load_reg;
        cmp_next   = cmp_reg;
        flag_next  = flag_reg;
        pre_next   = pre_reg;
        rd         = '0;
        case (opcode)
            OP_TICK:
            begin
                if (ctrl_reg[CR_EN] && (ctrl_reg[CR_CLKSRC_MSB:CR_CLKSRC_LSB] != 2'b00))
                begin
                    if (pre_reg != divider)
                    begin
                        pre_next = pre_reg + PRESCALE_WIDTH'(1);
                    end
                    else
                    begin
                        pre_next   = '0;
                        count_next = stepped;
                        if (stepped == cmp_reg)
                        begin
                            flag_next = 1'b1;
                        end
                    end
                end
            end
            OP_READ:
            begin
                case (reg_index)
                    REG_CR:   rd = ctrl_reg;
                    REG_SR:   rd = 32'(flag_reg);
                    REG_LR:   rd = 32'(load_reg);
                    REG_CMPR: rd = 32'(cmp_reg);
                    REG_CNR:  rd = 32'(count_reg);
                    default:  rd = '0;
                endcase
            end
            OP_WRITE:
            begin
                case (reg_index)
                    REG_CR:
                    begin
                        if (write_data[CR_SWR])
                        begin
                            ctrl_next  = '0;
                            count_next = '1;
                            load_next  = '1;
                            cmp_next   = '0;
                            flag_next  = 1'b0;
                            pre_next   = '0;
                        end
                        else
                        begin
                            ctrl_next = write_data & CR_KEEP;
                            // A rising enable with ENMOD restarts the count from the
                            // reload source selected by the new RLD bit.
                            if (!ctrl_reg[CR_EN] && write_data[CR_EN] && write_data[CR_ENMOD])
                            begin
                                count_next = write_data[CR_RLD] ? load_reg : '1;
                                pre_next   = '0;
                            end
                        end
                    end
                    REG_SR:
                    begin
                        if (write_data[SR_FLAG])
                        begin
                            flag_next = 1'b0;
                        end
                    end
                    REG_LR:
                    begin
                        load_next = write_data[COUNT_WIDTH-1:0];
                        if (ctrl_reg[CR_IOVW])
                        begin
                            count_next = write_data[COUNT_WIDTH-1:0];
                        end
                    end
                    REG_CMPR:
                    begin
                        cmp_next = write_data[COUNT_WIDTH-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            count_reg <= '1;
            load_reg  <= '1;
            cmp_reg   <= '0;
            flag_reg  <= 1'b0;
            pre_reg   <= '0;
        end
        else if (step_en)
        begin
            ctrl_reg  <= ctrl_next;
            count_reg <= count_next;
            load_reg  <= load_next;
            cmp_reg   <= cmp_next;
            flag_reg  <= flag_next;
            pre_reg   <= pre_next;
        end
    end

    assign result.read_data      = rd;
    assign result.compare_flag   = flag_next;
    assign result.interrupt_line = flag_next & ctrl_next[CR_OCIEN];

endmodule

// ===== rtl/enhanced_periodic_interrupt_timer.sv =====
// Periodic down-counting timer with compare, behind five 32-bit registers
// (control, status, load, compare, counter).
// Input channel (in_valid/in_ready): each transfer carries one operation:
// a tick of the selected clock, a register read or a register write.
// Output channel (out_valid/out_ready): exactly one result per input transfer,
// in order: read data (zero for ticks and writes), the compare flag and the
// interrupt line as they stand after that operation.
// The result is registered and appears on the output in the cycle after its
// input transfer. Throughput is one operation per cycle unless the receiver
// stalls, set by the single result stage; timer state updates in the same edge.
// A new operation is taken while the held result is being taken in the same
// cycle, so the block streams at full rate when the receiver keeps up.
// When the receiver stalls, the result stays on the output and in_ready drops
// until it is taken; no operation is applied to the timer in the meantime.
// Reset (rst_n low, asynchronous) clears the control register, the compare
// value, the flag and the prescaler, sets counter and load value to all ones
// and empties the output stage.
module enhanced_periodic_interrupt_timer
    import pit_pkg::*;
#(
    parameter int COUNT_WIDTH    = 32,
    parameter int PRESCALE_WIDTH = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        interrupt_line,
    output logic        compare_flag
);

    logic        accept;
    pit_result_t result;
    pit_result_t result_reg;
    logic        out_valid_reg, out_valid_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    pit_core #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .PRESCALE_WIDTH (PRESCALE_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .opcode     (opcode_t'(opcode)),
        .reg_index  (reg_index_t'(reg_index)),
        .write_data (write_data),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = result_reg.read_data;
    assign interrupt_line = result_reg.interrupt_line;
    assign compare_flag   = result_reg.compare_flag;

endmodule

// ===== rtl/pit_checker.sv =====
module pit_checker
    import pit_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  opcode,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data,
    input logic        interrupt_line,
    input logic        compare_flag
);

    // A held result must not change while the receiver stalls.
    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(interrupt_line) && $stable(compare_flag))
        else $error("result changed while stalled");

    // Every accepted operation produces a result in the next cycle.
    ast_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("result missing after input transfer");

    // The interrupt can only be raised while the compare flag is set.
    ast_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !interrupt_line || compare_flag)
        else $error("interrupt without compare flag");

    // Writes return zero read data.
    ast_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_WRITE) |=> read_data == 32'd0)
        else $error("write returned nonzero read data");

    // With an empty output stage the block always takes an operation.
    ast_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

endmodule

bind enhanced_periodic_interrupt_timer pit_checker u_pit_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .interrupt_line (interrupt_line),
    .compare_flag   (compare_flag)
);
